/* src/dma_slab_bitmap_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// dma slab bitmap allocator assertion macros
// shared concurrent assertion forms for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef DMA_SLAB_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define DMA_SLAB_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dsba_pkg.sv */
// ----------------------------------------------------------------------------
// dsba_pkg
// types, constants and helpers of the slab bitmap allocator
// ----------------------------------------------------------------------------
package dsba_pkg;

	localparam int NUM_PAGE_SLOTS = 8;
	localparam int SLOT_W         = $clog2(NUM_PAGE_SLOTS);
	localparam int MAP_WORDS      = 4;
	localparam int WORD_BITS      = 32;
	localparam int WIDX_W         = $clog2(WORD_BITS);
	localparam int MAP_BITS       = MAP_WORDS * WORD_BITS;
	localparam int IDX_W          = $clog2(MAP_BITS);
	localparam int FRAME_W        = 20;
	localparam int OFFS_W         = 12;
	localparam int SIZE_W         = 13;
	localparam int OPP_W          = 8;
	localparam int CNT_W          = 8;
	localparam int ADDR_W         = 32;
	localparam int PAGE_BYTES     = 4096;
	localparam int MIN_OBJ_SIZE   = 32;
	localparam int QUO_W          = 7;
	localparam int DIV_CNT_W      = $clog2(QUO_W);
	localparam int PROD_W         = SIZE_W + IDX_W;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS_PER_PAGE = 1'b1;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_DESTROY = 2'd2,
		REQ_NOP     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_PAGE  = 2'd1,
		STATUS_NOT_POOL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_SEL,
		S_ALLOC_SCAN,
		S_ALLOC_PICK,
		S_ALLOC_ADDR,
		S_FREE_DIV,
		S_FREE_RD,
		S_DONE
	} state_t;

	typedef struct packed {
		req_type_t            req_type;
		logic [FRAME_W-1:0]   fresh_frame;
		logic                 fresh_frame_ok;
		logic [ADDR_W-1:0]    free_address;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ADDR_W-1:0]    object_address;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic [SLOT_W-1:0]    waddr;
		logic [MAP_BITS-1:0]  wdata;
		logic                 re;
		logic [SLOT_W-1:0]    raddr;
	} ram_req_t;

	typedef struct packed {
		logic                 hit;
		logic [WIDX_W-1:0]    idx;
	} scan_t;

	// lowest set bit of one bitmap word
	function automatic scan_t lowest_set_word(input logic [WORD_BITS-1:0] v);
		scan_t r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.hit = 1'b1;
				r.idx = WIDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* src/dma_slab_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// dma_slab_bitmap_allocator_core
// fixed-size object allocator over 4 KiB pages with per-slot free bitmaps
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_data  (dsba_pkg::req_t)
//  out     | output    | out_valid / out_stall | out_data (dsba_pkg::rsp_t)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
//  one request is worked at a time; in_stall is low only while idle
//  allocate: the result follows the bitmap ram read and the two-level
//    lowest-free search; when no page can be had both are skipped, and when
//    the chosen page has no free bit the address step is skipped; destroy and unused codes go straight to the result
//  free: the result follows the 7-step offset divider and then the ram read;
//    the ram read is skipped when the address is outside the pool or past the last object
//  a result waiting on out_stall holds the block in its last state
//  reset clears slot valid bits and control; bitmap rows need no clearing
// ----------------------------------------------------------------------------
`include "dma_slab_bitmap_allocator_core_defines.svh"

module dma_slab_bitmap_allocator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dsba_pkg::req_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dsba_pkg::rsp_t                    out_data,
	input  logic                              cfg_we,
	input  logic [dsba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration
	logic [dsba_pkg::SIZE_W-1:0]   obj_size_q;
	logic [dsba_pkg::OPP_W-1:0]    opp_q;
	logic [dsba_pkg::SIZE_W-1:0]   size_eff;
	logic [dsba_pkg::OPP_W-1:0]    opp_eff;

	// per-slot state kept in flops, searched in parallel
	logic [dsba_pkg::NUM_PAGE_SLOTS-1:0] used_q;
	logic [dsba_pkg::FRAME_W-1:0]  frame_q [dsba_pkg::NUM_PAGE_SLOTS];
	logic [dsba_pkg::CNT_W-1:0]    cnt_q   [dsba_pkg::NUM_PAGE_SLOTS];

	// request context
	dsba_pkg::state_t              state_q, state_d;
	dsba_pkg::req_t                req_q;
	logic [dsba_pkg::SLOT_W-1:0]   pick_q;
	logic                          fresh_q;
	logic [dsba_pkg::IDX_W-1:0]    idx_q;
	logic [dsba_pkg::MAP_BITS-1:0] map_s2;
	dsba_pkg::scan_t               scan_s2 [dsba_pkg::MAP_WORDS];
	logic [dsba_pkg::PROD_W-1:0]   prod_q;
	dsba_pkg::status_t             res_status_q;
	logic [dsba_pkg::ADDR_W-1:0]   res_addr_q;

	// output register
	logic                          out_valid_q;
	dsba_pkg::rsp_t                out_data_q;

	logic                          in_xfer;
	logic                          load_out;
	dsba_pkg::ram_req_t            ram_req;
	logic [dsba_pkg::MAP_BITS-1:0] ram_rdata;
	logic                          div_done;
	logic [dsba_pkg::QUO_W-1:0]    div_quo;

	// slot searches
	logic                          nf_found, un_found, fr_found;
	logic [dsba_pkg::SLOT_W-1:0]   nf_pick, un_pick, fr_pick;
	logic [dsba_pkg::MAP_BITS-1:0] opp_mask;
	logic [dsba_pkg::MAP_BITS-1:0] map_cur;
	logic                          pick_hit;
	logic [dsba_pkg::IDX_W-1:0]    pick_idx;
	logic                          free_bad;

	// clamp registers to their working ranges
	always_comb begin
		if (obj_size_q < dsba_pkg::SIZE_W'(dsba_pkg::MIN_OBJ_SIZE)) begin
			size_eff = dsba_pkg::SIZE_W'(dsba_pkg::MIN_OBJ_SIZE);
		end else if (obj_size_q > dsba_pkg::SIZE_W'(dsba_pkg::PAGE_BYTES)) begin
			size_eff = dsba_pkg::SIZE_W'(dsba_pkg::PAGE_BYTES);
		end else begin
			size_eff = obj_size_q;
		end
		if (opp_q == '0) begin
			opp_eff = dsba_pkg::OPP_W'(1);
		end else if (opp_q > dsba_pkg::OPP_W'(dsba_pkg::MAP_BITS)) begin
			opp_eff = dsba_pkg::OPP_W'(dsba_pkg::MAP_BITS);
		end else begin
			opp_eff = opp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_size_q <= dsba_pkg::SIZE_W'(dsba_pkg::MIN_OBJ_SIZE);
			opp_q      <= dsba_pkg::OPP_W'(dsba_pkg::MAP_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsba_pkg::CFG_OBJECT_SIZE:      obj_size_q <= cfg_data;
				dsba_pkg::CFG_OBJECTS_PER_PAGE: opp_q <= cfg_data[dsba_pkg::OPP_W-1:0];
				default: ;
			endcase
		end
	end

	// newest non-full slot, lowest empty slot, newest slot owning the freed frame
	always_comb begin
		nf_found = 1'b0;
		nf_pick  = '0;
		fr_found = 1'b0;
		fr_pick  = '0;
		for (int s = 0; s < dsba_pkg::NUM_PAGE_SLOTS; s++) begin
			if (used_q[s] && cnt_q[s] < opp_eff) begin
				nf_found = 1'b1;
				nf_pick  = dsba_pkg::SLOT_W'(s);
			end
			if (used_q[s] && frame_q[s] == req_q.free_address[dsba_pkg::ADDR_W-1:
					dsba_pkg::OFFS_W]) begin
				fr_found = 1'b1;
				fr_pick  = dsba_pkg::SLOT_W'(s);
			end
		end
		un_found = 1'b0;
		un_pick  = '0;
		for (int s = dsba_pkg::NUM_PAGE_SLOTS - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				un_found = 1'b1;
				un_pick  = dsba_pkg::SLOT_W'(s);
			end
		end
	end

	// only the first opp_eff objects of a page count
	always_comb begin
		for (int i = 0; i < dsba_pkg::MAP_BITS; i++) begin
			opp_mask[i] = (dsba_pkg::OPP_W'(i) < opp_eff);
		end
	end

	// a fresh page starts all free
	assign map_cur = fresh_q ? '1 : ram_rdata;

	// second level of the lowest-free search over registered word results
	always_comb begin
		pick_hit = 1'b0;
		pick_idx = '0;
		for (int w = dsba_pkg::MAP_WORDS - 1; w >= 0; w--) begin
			if (scan_s2[w].hit) begin
				pick_hit = 1'b1;
				pick_idx = dsba_pkg::IDX_W'(w * dsba_pkg::WORD_BITS + int'(scan_s2[w].idx));
			end
		end
	end

	// free outside the pool or past the last object
	assign free_bad = !fr_found || {1'b0, div_quo} >= opp_eff;

	assign in_stall = (state_q != dsba_pkg::S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// next state and ram control
	always_comb begin
		state_d       = state_q;
		load_out      = 1'b0;
		ram_req       = '0;
		ram_req.raddr = nf_pick;
		ram_req.waddr = pick_q;
		unique case (state_q)
			dsba_pkg::S_IDLE: begin
				if (in_xfer) begin
					priority case (in_data.req_type)
						dsba_pkg::REQ_ALLOC: state_d = dsba_pkg::S_ALLOC_SEL;
						dsba_pkg::REQ_FREE:  state_d = dsba_pkg::S_FREE_DIV;
						default:             state_d = dsba_pkg::S_DONE;
					endcase
				end
			end
			dsba_pkg::S_ALLOC_SEL: begin
				if (nf_found) begin
					ram_req.re = 1'b1;
					state_d    = dsba_pkg::S_ALLOC_SCAN;
				end else if (!req_q.fresh_frame_ok || !un_found) begin
					state_d = dsba_pkg::S_DONE;
				end else begin
					state_d = dsba_pkg::S_ALLOC_SCAN;
				end
			end
			dsba_pkg::S_ALLOC_SCAN: begin
				state_d = dsba_pkg::S_ALLOC_PICK;
			end
			dsba_pkg::S_ALLOC_PICK: begin
				if (pick_hit) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = map_s2 & ~(dsba_pkg::MAP_BITS'(1) << pick_idx);
					state_d       = dsba_pkg::S_ALLOC_ADDR;
				end else begin
					state_d = dsba_pkg::S_DONE;
				end
			end
			dsba_pkg::S_ALLOC_ADDR: begin
				state_d = dsba_pkg::S_DONE;
			end
			dsba_pkg::S_FREE_DIV: begin
				ram_req.raddr = fr_pick;
				if (div_done) begin
					if (free_bad) begin
						state_d = dsba_pkg::S_DONE;
					end else begin
						ram_req.re = 1'b1;
						state_d    = dsba_pkg::S_FREE_RD;
					end
				end
			end
			dsba_pkg::S_FREE_RD: begin
				// double free leaves the row alone
				if (!ram_rdata[idx_q]) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = ram_rdata | (dsba_pkg::MAP_BITS'(1) << idx_q);
				end
				state_d = dsba_pkg::S_DONE;
			end
			dsba_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = dsba_pkg::S_IDLE;
				end
			end
			default: state_d = dsba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (in_xfer && in_data.req_type == dsba_pkg::REQ_DESTROY) begin
			used_q <= '0;
		end else if (state_q == dsba_pkg::S_ALLOC_PICK && pick_hit && fresh_q) begin
			used_q[pick_q] <= 1'b1;
		end
	end

	// request context, slot payload and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			dsba_pkg::S_IDLE: begin
				if (in_xfer) begin
					req_q        <= in_data;
					res_status_q <= dsba_pkg::STATUS_OK;
					res_addr_q   <= '0;
				end
			end
			dsba_pkg::S_ALLOC_SEL: begin
				fresh_q <= !nf_found;
				pick_q  <= nf_found ? nf_pick : un_pick;
				if (!nf_found && (!req_q.fresh_frame_ok || !un_found)) begin
					res_status_q <= dsba_pkg::STATUS_NO_PAGE;
				end
			end
			dsba_pkg::S_ALLOC_SCAN: begin
				map_s2 <= map_cur;
				for (int w = 0; w < dsba_pkg::MAP_WORDS; w++) begin
					scan_s2[w] <= dsba_pkg::lowest_set_word(
						map_cur[w*dsba_pkg::WORD_BITS +: dsba_pkg::WORD_BITS] &
						opp_mask[w*dsba_pkg::WORD_BITS +: dsba_pkg::WORD_BITS]);
				end
			end
			dsba_pkg::S_ALLOC_PICK: begin
				if (pick_hit) begin
					prod_q <= dsba_pkg::PROD_W'(size_eff) * dsba_pkg::PROD_W'(pick_idx);
					if (fresh_q) begin
						frame_q[pick_q] <= req_q.fresh_frame;
						cnt_q[pick_q]   <= dsba_pkg::CNT_W'(1);
					end else begin
						cnt_q[pick_q]   <= cnt_q[pick_q] + dsba_pkg::CNT_W'(1);
					end
				end else begin
					res_status_q <= dsba_pkg::STATUS_NO_PAGE;
				end
			end
			dsba_pkg::S_ALLOC_ADDR: begin
				// frame times page size plus object offset, wrapping at 32 bits
				res_addr_q <= {frame_q[pick_q], dsba_pkg::OFFS_W'(0)} +
					dsba_pkg::ADDR_W'(prod_q);
			end
			dsba_pkg::S_FREE_DIV: begin
				if (div_done) begin
					pick_q <= fr_pick;
					idx_q  <= div_quo;
					if (free_bad) begin
						res_status_q <= dsba_pkg::STATUS_NOT_POOL;
					end
				end
			end
			dsba_pkg::S_FREE_RD: begin
				if (!ram_rdata[idx_q] && cnt_q[pick_q] != '0) begin
					cnt_q[pick_q] <= cnt_q[pick_q] - dsba_pkg::CNT_W'(1);
				end
			end
			dsba_pkg::S_DONE: ;
			default: ;
		endcase
	end

	// output register, free again once its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.status         <= res_status_q;
			out_data_q.object_address <= res_addr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	dsba_map_ram u_map_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// offset within the page divided by object size
	dsba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer && in_data.req_type == dsba_pkg::REQ_FREE),
		.dividend (in_data.free_address[dsba_pkg::OFFS_W-1:0]),
		.divisor  (size_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	`DSBA_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, in_xfer, state_q != dsba_pkg::S_IDLE, "request transfer did not leave idle")
	`DSBA_ASSERT_NOW(a_ram_single_port, clk, arst_n, ram_req.we, !ram_req.re, "bitmap ram read and write in one cycle")
	`DSBA_ASSERT_NOW(a_load_when_free, clk, arst_n, load_out, !out_valid_q || !out_stall, "result loaded over a stalled result")
	`DSBA_ASSERT_NOW(a_div_done_in_free, clk, arst_n, div_done, state_q == dsba_pkg::S_FREE_DIV, "divider finished outside a free request")

endmodule

/* src/dsba_map_ram.sv */
// ----------------------------------------------------------------------------
// dsba_map_ram
// free bitmap store, one row per page slot, registered read
// ----------------------------------------------------------------------------
module dsba_map_ram (
	input  logic                          clk,
	input  dsba_pkg::ram_req_t            req,
	output logic [dsba_pkg::MAP_BITS-1:0] rdata
);

	logic [dsba_pkg::MAP_BITS-1:0] mem [dsba_pkg::NUM_PAGE_SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* src/dsba_div.sv */
// ----------------------------------------------------------------------------
// dsba_div
// restoring divider for page offset by object size, one quotient bit a cycle
// ----------------------------------------------------------------------------
module dsba_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dsba_pkg::OFFS_W-1:0]   dividend,
	input  logic [dsba_pkg::SIZE_W-1:0]   divisor,
	output logic                          done,
	output logic [dsba_pkg::QUO_W-1:0]    quotient
);

	localparam int SH_W = dsba_pkg::SIZE_W + dsba_pkg::QUO_W - 1;

	logic                               busy_q;
	logic                               done_q;
	logic [dsba_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [dsba_pkg::OFFS_W-1:0]        rem_q;
	logic [dsba_pkg::QUO_W-1:0]         quo_q;
	logic [dsba_pkg::SIZE_W-1:0]        div_q;
	logic [SH_W-1:0]                    trial;
	logic                               ge;

	assign trial = SH_W'(div_q) << cnt_q;
	assign ge    = SH_W'(rem_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= dsba_pkg::DIV_CNT_W'(dsba_pkg::QUO_W - 1);
			rem_q <= dividend;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			quo_q[cnt_q] <= ge;
			if (ge) begin
				rem_q <= rem_q - dsba_pkg::OFFS_W'(trial);
			end
			cnt_q <= cnt_q - dsba_pkg::DIV_CNT_W'(1);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
